/* src/moie_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package moie_pkg;

    localparam int REG_AW    = 9;
    localparam int REG_COUNT = 1 << REG_AW;

    localparam int DEST_W = 9;
    localparam int DATA_W = 32;

    // opcodes
    localparam logic [3:0] OP_SET   = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_JMP   = 4'd3;
    localparam logic [3:0] OP_JMZ   = 4'd4;
    localparam logic [3:0] OP_CMP   = 4'd5;
    localparam logic [3:0] OP_PRINT = 4'd6;
    localparam logic [3:0] OP_HALT  = 4'd7;

    // operand kinds
    localparam logic [1:0] KIND_IMM = 2'd0;
    localparam logic [1:0] KIND_REG = 2'd1;

    typedef struct packed {
        logic [3:0]        mode;
        logic [DEST_W-1:0] dest_index;
        logic [1:0]        first_kind;
        logic [DATA_W-1:0] first_value;
        logic [1:0]        second_kind;
        logic [DATA_W-1:0] second_value;
    } instr_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } wr_port_t;

    typedef struct packed {
        logic              jump_taken;
        logic [DATA_W-1:0] jump_target;
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
        logic              halted;
        logic              bad_opcode;
    } result_t;

    // register index from an operand value, low bits only
    function automatic logic [REG_AW-1:0] value_addr(input logic [DATA_W-1:0] v);
        return v[REG_AW-1:0];
    endfunction

    // register index from the destination field
    function automatic logic [REG_AW-1:0] dest_addr(input logic [DEST_W-1:0] d);
        logic [DATA_W-1:0] w;
        w = {{(DATA_W-DEST_W){1'b0}}, d};
        return w[REG_AW-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/memory_operand_instruction_execute.sv */
`timescale 1ns / 1ps
`default_nettype none

// Executes one decoded instruction per transaction against a 512 x 32-bit register file
// held in a memory with two registered read ports and one write port. An instruction is
// accepted and its register reads are issued at the accepting edge; it then executes, writes
// back and loads the output register once the output register is free or being taken, so one
// instruction per clock is sustained while m_axis_tready does not stall the output. A write
// and a read of the same entry at the same edge are forwarded. After reset a clearing pass
// zeroes the register file, and s_axis_tready stays low until it finishes. After halt or an
// unknown opcode, later instructions only report the flags until reset.
module memory_operand_instruction_execute (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // dest_index, first_value, second_value, zero fill
    input  wire logic [79:0] s_axis_tdata,
    // mode, first_kind, second_kind
    input  wire logic [7:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // jump_target, print_value
    output logic [63:0]      m_axis_tdata,
    // jump_taken, print_valid, halted, bad_opcode, zero fill
    output logic [7:0]       m_axis_tuser
);

    moie_pkg::instr_t                instr;
    moie_pkg::result_t               result;
    moie_pkg::wr_port_t              wr;
    logic                            busy;
    logic                            rd_en;
    logic [moie_pkg::REG_AW-1:0]     rd_addr_a;
    logic [moie_pkg::REG_AW-1:0]     rd_addr_b;
    logic [moie_pkg::DATA_W-1:0]     rd_data_a;
    logic [moie_pkg::DATA_W-1:0]     rd_data_b;

    assign instr.mode         = s_axis_tuser[3:0];
    assign instr.first_kind   = s_axis_tuser[5:4];
    assign instr.second_kind  = s_axis_tuser[7:6];
    assign instr.dest_index   = s_axis_tdata[8:0];
    assign instr.first_value  = s_axis_tdata[40:9];
    assign instr.second_value = s_axis_tdata[72:41];

    moie_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr        (wr),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .busy      (busy)
    );

    moie_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .busy       (busy),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_instr   (instr),
        .rd_en      (rd_en),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .wr         (wr),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {result.print_value, result.jump_target};
    assign m_axis_tuser = {4'b0000, result.bad_opcode, result.halted,
                           result.print_valid, result.jump_taken};

endmodule

`default_nettype wire

/* src/moie_regfile.sv */
`timescale 1ns / 1ps
`default_nettype none

module moie_regfile (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [moie_pkg::REG_AW-1:0]   rd_addr_a,
    input  wire logic [moie_pkg::REG_AW-1:0]   rd_addr_b,
    input  wire moie_pkg::wr_port_t            wr,
    output logic [moie_pkg::DATA_W-1:0]        rd_data_a,
    output logic [moie_pkg::DATA_W-1:0]        rd_data_b,
    output logic                               busy
);

    logic [moie_pkg::DATA_W-1:0] mem [moie_pkg::REG_COUNT];

    logic [moie_pkg::DATA_W-1:0] rd_q_a_reg;
    logic [moie_pkg::DATA_W-1:0] rd_q_b_reg;
    logic                        fwd_a_reg;
    logic                        fwd_b_reg;
    logic [moie_pkg::DATA_W-1:0] fwd_data_reg;

    logic                        clear_busy_reg;
    logic                        clear_busy_next;
    logic [moie_pkg::REG_AW-1:0] clear_addr_reg;
    logic [moie_pkg::REG_AW-1:0] clear_addr_next;

    moie_pkg::wr_port_t          wr_eff;

    // clearing pass owns the write port after reset
    always_comb
    begin
        if (clear_busy_reg)
        begin
            wr_eff.en   = 1'b1;
            wr_eff.addr = clear_addr_reg;
            wr_eff.data = '0;
        end
        else
        begin
            wr_eff = wr;
        end
        clear_addr_next = clear_addr_reg + 1'b1;
        clear_busy_next = clear_busy_reg && !(&clear_addr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_eff.en)
        begin
            mem[wr_eff.addr] <= wr_eff.data;
        end
        if (rd_en)
        begin
            rd_q_a_reg   <= mem[rd_addr_a];
            rd_q_b_reg   <= mem[rd_addr_b];
            // read and write of one entry at the same edge: take the new value
            fwd_a_reg    <= wr_eff.en && (wr_eff.addr == rd_addr_a);
            fwd_b_reg    <= wr_eff.en && (wr_eff.addr == rd_addr_b);
            fwd_data_reg <= wr_eff.data;
        end
    end

    assign rd_data_a = fwd_a_reg ? fwd_data_reg : rd_q_a_reg;
    assign rd_data_b = fwd_b_reg ? fwd_data_reg : rd_q_b_reg;
    assign busy      = clear_busy_reg;

`ifndef SYNTHESIS
    a_no_read_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !rd_en)
        else $error("register read issued during clearing pass");

    a_no_exec_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !wr.en)
        else $error("execute write during clearing pass");

    a_clear_ends_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_busy_reg |=> !clear_busy_reg)
        else $error("clearing pass restarted without reset");
`endif

endmodule

`default_nettype wire

/* src/moie_exec.sv */
`timescale 1ns / 1ps
`default_nettype none

module moie_exec (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          busy,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire moie_pkg::instr_t              in_instr,
    output logic                               rd_en,
    output logic [moie_pkg::REG_AW-1:0]        rd_addr_a,
    output logic [moie_pkg::REG_AW-1:0]        rd_addr_b,
    input  wire logic [moie_pkg::DATA_W-1:0]   rd_data_a,
    input  wire logic [moie_pkg::DATA_W-1:0]   rd_data_b,
    output moie_pkg::wr_port_t                 wr,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output moie_pkg::result_t                  out_result
);

    moie_pkg::instr_t            ex_reg;
    logic                        ex_valid_reg;
    logic                        ex_valid_next;
    logic                        ex_fire;

    logic                        stopped_reg;
    logic                        stopped_next;
    logic                        error_reg;
    logic                        error_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    moie_pkg::result_t           res_reg;
    moie_pkg::result_t           res_next;

    logic                        ok1;
    logic                        ok2;
    logic [moie_pkg::DATA_W-1:0] opa;
    logic [moie_pkg::DATA_W-1:0] opb;
    logic [moie_pkg::DATA_W-1:0] sum;
    logic [moie_pkg::DATA_W-1:0] cmp_val;
    logic                        wr_en_raw;
    logic [moie_pkg::REG_AW-1:0] wr_addr;
    logic [moie_pkg::DATA_W-1:0] wr_data;

    assign ex_fire  = ex_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !busy && (!ex_valid_reg || ex_fire);
    assign rd_en    = in_valid && in_ready;

    // port a serves the first operand, port b the tested register or the second operand
    assign rd_addr_b = (in_instr.mode == moie_pkg::OP_JMZ || in_instr.mode == moie_pkg::OP_CMP)
                       ? moie_pkg::dest_addr(in_instr.dest_index)
                       : moie_pkg::value_addr(in_instr.second_value);
    assign rd_addr_a = moie_pkg::value_addr(in_instr.first_value);

    always_comb
    begin
        ok1 = (ex_reg.first_kind == moie_pkg::KIND_IMM) ||
              (ex_reg.first_kind == moie_pkg::KIND_REG);
        ok2 = (ex_reg.second_kind == moie_pkg::KIND_IMM) ||
              (ex_reg.second_kind == moie_pkg::KIND_REG);
        if (ex_reg.first_kind == moie_pkg::KIND_IMM)
            opa = ex_reg.first_value;
        else if (ex_reg.first_kind == moie_pkg::KIND_REG)
            opa = rd_data_a;
        else
            opa = '0;
        if (ex_reg.second_kind == moie_pkg::KIND_IMM)
            opb = ex_reg.second_value;
        else if (ex_reg.second_kind == moie_pkg::KIND_REG)
            opb = rd_data_b;
        else
            opb = '0;

        sum = (ex_reg.mode == moie_pkg::OP_SUB) ? (opa - opb) : (opa + opb);

        // signed three-way compare of tested register against operand
        if (rd_data_b == opa)
            cmp_val = '0;
        else if ($signed(rd_data_b) > $signed(opa))
            cmp_val = {{(moie_pkg::DATA_W-1){1'b0}}, 1'b1};
        else
            cmp_val = '1;

        wr_en_raw    = 1'b0;
        wr_addr      = moie_pkg::dest_addr(ex_reg.dest_index);
        wr_data      = opa;
        stopped_next = stopped_reg;
        error_next   = error_reg;
        res_next     = '0;

        if (!stopped_reg && !error_reg)
        begin
            case (ex_reg.mode)
                moie_pkg::OP_SET:
                begin
                    wr_en_raw = ok1;
                end
                moie_pkg::OP_ADD, moie_pkg::OP_SUB:
                begin
                    wr_en_raw = 1'b1;
                    wr_data   = ok2 ? sum : opa;
                end
                moie_pkg::OP_JMP:
                begin
                    res_next.jump_taken  = ok1;
                    res_next.jump_target = ok1 ? opa : '0;
                end
                moie_pkg::OP_JMZ:
                begin
                    if (ok1 && rd_data_b == '0)
                    begin
                        res_next.jump_taken  = 1'b1;
                        res_next.jump_target = opa;
                    end
                end
                moie_pkg::OP_CMP:
                begin
                    wr_en_raw = 1'b1;
                    wr_addr   = '0;
                    wr_data   = cmp_val;
                end
                moie_pkg::OP_PRINT:
                begin
                    res_next.print_valid = 1'b1;
                    res_next.print_value = opa;
                end
                moie_pkg::OP_HALT:
                begin
                    stopped_next = 1'b1;
                end
                default:
                begin
                    error_next = 1'b1;
                end
            endcase
        end
        res_next.halted     = stopped_next;
        res_next.bad_opcode = error_next;

        ex_valid_next  = rd_en ? 1'b1 : (ex_fire ? 1'b0 : ex_valid_reg);
        out_valid_next = ex_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign wr.en   = wr_en_raw && ex_fire;
    assign wr.addr = wr_addr;
    assign wr.data = wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stopped_reg   <= 1'b0;
            error_reg     <= 1'b0;
        end
        else
        begin
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
            if (ex_fire)
            begin
                stopped_reg <= stopped_next;
                error_reg   <= error_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ex_reg <= in_instr;
        end
        if (ex_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

`ifndef SYNTHESIS
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("halted state cleared without reset");

    a_halt_error_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(stopped_reg && error_reg))
        else $error("halt and error both set");

    a_no_write_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (stopped_reg || error_reg) |-> !wr.en)
        else $error("register write after machine stopped");

    a_jump_print_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.jump_taken && res_reg.print_valid))
        else $error("jump and print reported by one transaction");
`endif

endmodule

`default_nettype wire
